FILE: rtl/bbpe_pkg.sv
// Shared types and constants of the bicubic Bezier patch evaluator.
package bbpe_pkg;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_EVAL = 1'b1
   } action_type;

   // Width of each normal component on the result ports.
   localparam int NRM_WIDTH = 40;

   // Cycles from an accepted evaluate transaction to its result strobe.
   localparam int EVAL_LATENCY = 8;

   // Tangent saturation limit, +-(2^31 - 1).
   localparam longint TAN_LIMIT = 64'sd2147483647;

endpackage

FILE: rtl/bbpe_decas.sv
// Three-stage pipelined de Casteljau evaluation of one cubic curve.
module bbpe_decas
   import bbpe_pkg::*;
#(
   parameter int C = 16,
   parameter int F = 15
) (
   input  logic                 clock,
   input  logic signed [C-1:0]  p [4],
   input  logic        [F:0]    s,
   output logic signed [C-1:0]  val,
   output logic signed [(C+3 > 32 ? 32 : C+3)-1:0] tan,
   output logic        [F:0]    s_out
);

   localparam int TW  = (C + 3 > 32) ? 32 : C + 3;
   localparam int TXW = (C + 3 > 33) ? C + 3 : 33;
   localparam int PW  = C + F + 3;
   localparam logic signed [PW-1:0]  HALF = PW'(1) << (F - 1);
   localparam logic signed [TXW-1:0] TMAX = TXW'(TAN_LIMIT);
   localparam logic signed [TXW-1:0] TMIN = -TMAX;

   // a + round((b - a) * s / 2^F), half up; the result stays between a and b
   function automatic logic signed [C-1:0] lerp(input logic signed [C-1:0] a,
                                                input logic signed [C-1:0] b,
                                                input logic [F:0] w);
      logic signed [C:0]    d;
      logic signed [PW-1:0] pr;
      d  = {b[C-1], b} - {a[C-1], a};
      pr = d * $signed({1'b0, w});
      pr = pr + HALF;
      return a + pr[C+F-1:F];
   endfunction

   logic signed [C-1:0] a_ff [3];
   logic        [F:0]   s1_ff, s2_ff;
   logic signed [C-1:0] b0_ff, b1_ff;
   logic signed [C:0]   dt;
   logic signed [C+2:0] tf;
   logic signed [TXW-1:0] te;
   logic signed [TW-1:0] tan_in;

   always_comb begin
      dt = {b1_ff[C-1], b1_ff} - {b0_ff[C-1], b0_ff};
      tf = (C+3)'(dt) + ((C+3)'(dt) <<< 1);
      te = tf;
      if (te > TMAX) begin
         te = TMAX;
      end else if (te < TMIN) begin
         te = TMIN;
      end
      tan_in = te[TW-1:0];
   end

   always_ff @(posedge clock) begin
      a_ff[0] <= lerp(p[0], p[1], s);
      a_ff[1] <= lerp(p[1], p[2], s);
      a_ff[2] <= lerp(p[2], p[3], s);
      s1_ff   <= s;
      b0_ff   <= lerp(a_ff[0], a_ff[1], s1_ff);
      b1_ff   <= lerp(a_ff[1], a_ff[2], s1_ff);
      s2_ff   <= s1_ff;
      val     <= lerp(b0_ff, b1_ff, s2_ff);
      tan     <= tan_in;
      s_out   <= s2_ff;
   end

endmodule

FILE: rtl/bicubic_bezier_patch_eval_unit.sv
// Top level of the bicubic Bezier patch evaluator.
// A load transaction (req_action = load) writes one control point at req_row,
// req_col; it gives no result. An evaluate transaction gives the surface point
// and the unnormalized normal cross(dS/dv, dS/du), marked by rsp_strobe for
// one cycle. busy is always low: the block takes one transaction per cycle,
// any mix of loads and evaluates, and the receiver cannot stall it. The
// latency is set by two three-stage de Casteljau pipelines in series (grid
// lines, then the four line results), one stage of tangent products and one
// stage of cross-product subtraction and saturation. An evaluate sees every
// load accepted before it.
module bicubic_bezier_patch_eval_unit
   import bbpe_pkg::*;
#(
   parameter int COORD_WIDTH     = 16,
   parameter int PARAM_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [1:0]                    req_row,
   input  logic [1:0]                    req_col,
   input  logic signed [COORD_WIDTH-1:0] req_px,
   input  logic signed [COORD_WIDTH-1:0] req_py,
   input  logic signed [COORD_WIDTH-1:0] req_pz,
   input  logic [15:0]                   req_u,
   input  logic [15:0]                   req_v,
   output logic                          rsp_strobe,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   output logic signed [COORD_WIDTH-1:0] rsp_point_z,
   output logic signed [NRM_WIDTH-1:0]   rsp_normal_x,
   output logic signed [NRM_WIDTH-1:0]   rsp_normal_y,
   output logic signed [NRM_WIDTH-1:0]   rsp_normal_z
);

   localparam int C   = COORD_WIDTH;
   localparam int F   = PARAM_FRAC_BITS;
   localparam int TW  = (C + 3 > 32) ? 32 : C + 3;
   localparam int NW  = 2 * TW + 1;
   localparam int NXW = (NW > NRM_WIDTH + 1) ? NW : NRM_WIDTH + 1;
   localparam logic signed [NXW-1:0] NMAX = NXW'((64'sd1 <<< (NRM_WIDTH - 1)) - 1);
   localparam logic signed [NXW-1:0] NMIN = -NMAX - NXW'(1);
   localparam logic [31:0] ONE = 32'(1) << F;

   // Control point grid, entry index row*4 + col, coordinates x, y, z.
   logic signed [C-1:0] cp_ff [16][3];

   logic              accept;
   logic [F:0]        u_sat, v_sat;
   logic [EVAL_LATENCY-1:0] vld_ff, vld_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Saturate the parameters to exactly one.
   assign u_sat = ({16'b0, req_u} > ONE) ? (F+1)'(ONE) : (F+1)'(req_u);
   assign v_sat = ({16'b0, req_v} > ONE) ? (F+1)'(ONE) : (F+1)'(req_v);

   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_LOAD) begin
         cp_ff[{req_row, req_col}][0] <= req_px;
         cp_ff[{req_row, req_col}][1] <= req_py;
         cp_ff[{req_row, req_col}][2] <= req_pz;
      end
   end

   // Valid bits travel alongside the arithmetic pipeline.
   assign vld_in = {vld_ff[EVAL_LATENCY-2:0], accept && req_action == ACT_EVAL};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Per coordinate: first level over columns (along u) and rows (along v),
   // then one cubic over each set of four results.
   logic signed [C-1:0]  col_p [3][4][4];
   logic signed [C-1:0]  row_p [3][4][4];
   logic signed [C-1:0]  along_u [3][4];
   logic signed [C-1:0]  along_v [3][4];
   logic signed [TW-1:0] t_unused_u [3][4];
   logic signed [TW-1:0] t_unused_v [3][4];
   logic [F:0]           u_d [3][4];
   logic [F:0]           v_d [3][4];
   logic signed [C-1:0]  pt [3];
   logic signed [C-1:0]  pt_unused [3];
   logic signed [TW-1:0] tv [3];
   logic signed [TW-1:0] tu [3];
   logic [F:0]           s_unused_a [3];
   logic [F:0]           s_unused_b [3];

   for (genvar c = 0; c < 3; c++) begin : g_coord
      for (genvar i = 0; i < 4; i++) begin : g_line
         for (genvar j = 0; j < 4; j++) begin : g_tap
            assign col_p[c][i][j] = cp_ff[j*4+i][c];
            assign row_p[c][i][j] = cp_ff[i*4+j][c];
         end
         bbpe_decas #(.C(C), .F(F)) u_col (
            .clock(clock), .p(col_p[c][i]), .s(u_sat),
            .val(along_u[c][i]), .tan(t_unused_u[c][i]), .s_out(u_d[c][i])
         );
         bbpe_decas #(.C(C), .F(F)) u_row (
            .clock(clock), .p(row_p[c][i]), .s(v_sat),
            .val(along_v[c][i]), .tan(t_unused_v[c][i]), .s_out(v_d[c][i])
         );
      end
      // Curve of the column results runs in v: point and v-tangent.
      bbpe_decas #(.C(C), .F(F)) u_su (
         .clock(clock), .p(along_u[c]), .s(v_d[c][0]),
         .val(pt[c]), .tan(tv[c]), .s_out(s_unused_a[c])
      );
      // Curve of the row results runs in u: u-tangent.
      bbpe_decas #(.C(C), .F(F)) u_sv (
         .clock(clock), .p(along_v[c]), .s(u_d[c][0]),
         .val(pt_unused[c]), .tan(tu[c]), .s_out(s_unused_b[c])
      );
   end

   // Product stage: hold the six tangent products and the point.
   logic signed [2*TW-1:0] pr_ff [6];
   logic signed [C-1:0]    pt_ff [3];

   always_ff @(posedge clock) begin
      pr_ff[0] <= tv[1] * tu[2];
      pr_ff[1] <= tv[2] * tu[1];
      pr_ff[2] <= tv[2] * tu[0];
      pr_ff[3] <= tv[0] * tu[2];
      pr_ff[4] <= tv[0] * tu[1];
      pr_ff[5] <= tv[1] * tu[0];
      pt_ff    <= pt;
   end

   // Subtract and saturate each normal component to the 40-bit range.
   function automatic logic signed [NRM_WIDTH-1:0] cross_sat(
      input logic signed [2*TW-1:0] a,
      input logic signed [2*TW-1:0] b);
      logic signed [NXW-1:0] d;
      d = NXW'(a) - NXW'(b);
      if (d > NMAX) begin
         d = NMAX;
      end else if (d < NMIN) begin
         d = NMIN;
      end
      return d[NRM_WIDTH-1:0];
   endfunction

   always_ff @(posedge clock) begin
      rsp_point_x  <= pt_ff[0];
      rsp_point_y  <= pt_ff[1];
      rsp_point_z  <= pt_ff[2];
      rsp_normal_x <= cross_sat(pr_ff[0], pr_ff[1]);
      rsp_normal_y <= cross_sat(pr_ff[2], pr_ff[3]);
      rsp_normal_z <= cross_sat(pr_ff[4], pr_ff[5]);
   end

   assign rsp_strobe = vld_ff[EVAL_LATENCY-1];

endmodule

FILE: rtl/bbpe_checker.sv
// Port-level checker of the patch evaluator and its bind.
module bbpe_checker
   import bbpe_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_action,
   input logic rsp_strobe
);

   // Every evaluate transaction yields a strobe at the evaluation latency.
   a_eval_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_EVAL) |-> ##EVAL_LATENCY rsp_strobe)
      else $error("evaluate transaction lost");

   // A load transaction never produces a result.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_LOAD) |-> ##EVAL_LATENCY !rsp_strobe)
      else $error("load transaction produced a result");

   // No strobe without an evaluate transaction behind it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_action == ACT_EVAL, EVAL_LATENCY))
      else $error("result without evaluate transaction");

endmodule

bind bicubic_bezier_patch_eval_unit bbpe_checker u_bbpe_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_action(req_action), .rsp_strobe(rsp_strobe)
);

FILE: tb/sv/bicubic_bezier_patch_eval_unit_test.sv
// Testbench for the bicubic Bezier patch evaluator: directed and random loads and evaluations, self-checked.
`timescale 1ns / 100ps
module bicubic_bezier_patch_eval_unit_test
   import bbpe_pkg::*;
;

   localparam int  RANDOM_ITEMS = 1900;
   localparam int  CALM_TAIL    = 150;   // last items driven without random gaps
   localparam int  STALL_LIMIT  = 5000;  // cycles with no transaction at all
   localparam longint ONE       = 64'sd32768;
   localparam longint NRM_HI    = 64'sd549755813887;
   localparam longint NRM_LO    = -64'sd549755813888;

   typedef struct {
      action_type  action;
      logic [1:0]  row;
      logic [1:0]  col;
      logic [15:0] px, py, pz;
      logic [15:0] u, v;
      bit          drain;   // hold off until every pending result has come
      bit          calm;    // no idle burst after this item
   } patch_item_type;

   typedef struct {
      logic signed [15:0] px, py, pz;
      logic signed [39:0] nx, ny, nz;
   } surface_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic [1:0] req_row = '0, req_col = '0;
   logic signed [15:0] req_px = '0, req_py = '0, req_pz = '0;
   logic [15:0] req_u = '0, req_v = '0;
   logic rsp_strobe;
   logic signed [15:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic signed [39:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;

   patch_item_type     pending_items[$];
   surface_sample_type expected_samples[$];
   longint             grid_pts[16][3];   // predictor copy of the control grid
   int                 mismatches = 0;
   int                 idle_cycles = 0;
   int                 gap_left = 0;
   logic               taken = 1'b0;

   always #2 clock = ~clock;   // 4 ns period

   bicubic_bezier_patch_eval_unit dut (
      .clock, .reset, .start, .busy, .req_action, .req_row, .req_col,
      .req_px, .req_py, .req_pz, .req_u, .req_v, .rsp_strobe,
      .rsp_point_x, .rsp_point_y, .rsp_point_z,
      .rsp_normal_x, .rsp_normal_y, .rsp_normal_z
   );

   // a + round((b - a) * s / 2^15), rounding half up; >>> floors signed values
   function automatic longint lerp_round(longint a, longint b, longint s);
      return a + (((b - a) * s + 64'sd16384) >>> 15);
   endfunction

   // de Casteljau on one cubic: value and clamped tangent 3 * (q1 - q0)
   function automatic void cubic_point(input longint p[4], input longint s,
                                       output longint val, output longint tan);
      longint a0, a1, a2, b0, b1;
      a0 = lerp_round(p[0], p[1], s);
      a1 = lerp_round(p[1], p[2], s);
      a2 = lerp_round(p[2], p[3], s);
      b0 = lerp_round(a0, a1, s);
      b1 = lerp_round(a1, a2, s);
      val = lerp_round(b0, b1, s);
      tan = 3 * (b1 - b0);
      if (tan > TAN_LIMIT) tan = TAN_LIMIT;
      if (tan < -TAN_LIMIT) tan = -TAN_LIMIT;
   endfunction

   function automatic longint clamp_normal(longint x);
      return x > NRM_HI ? NRM_HI : (x < NRM_LO ? NRM_LO : x);
   endfunction

   function automatic surface_sample_type sample_patch(logic [15:0] u_raw,
                                                       logic [15:0] v_raw);
      surface_sample_type r;
      longint su, sv, pt[3], tv[3], tu[3], along_u[4], along_v[4], line[4], dummy, tmp;
      su = (u_raw > ONE) ? ONE : longint'(u_raw);
      sv = (v_raw > ONE) ? ONE : longint'(v_raw);
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) line[j] = grid_pts[j*4+i][c];
            cubic_point(line, su, along_u[i], dummy);
            for (int j = 0; j < 4; j++) line[j] = grid_pts[i*4+j][c];
            cubic_point(line, sv, along_v[i], dummy);
         end
         cubic_point(along_u, sv, pt[c], tv[c]);
         cubic_point(along_v, su, tmp, tu[c]);
      end
      r.px = pt[0][15:0];
      r.py = pt[1][15:0];
      r.pz = pt[2][15:0];
      r.nx = 40'(clamp_normal(tv[1]*tu[2] - tv[2]*tu[1]));
      r.ny = 40'(clamp_normal(tv[2]*tu[0] - tv[0]*tu[2]));
      r.nz = 40'(clamp_normal(tv[0]*tu[1] - tv[1]*tu[0]));
      return r;
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(0, 63)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly legal parameters with the endpoints; sometimes any 16-bit value.
   function automatic logic [15:0] pick_param();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   function automatic patch_item_type load_item(int r, int c, logic [15:0] x, logic [15:0] y,
                                                logic [15:0] z, bit calm);
      patch_item_type it;
      it = '{ACT_LOAD, 2'(r), 2'(c), x, y, z, 16'($urandom), 16'($urandom), 1'b0, calm};
      return it;
   endfunction

   function automatic patch_item_type eval_item(logic [15:0] u, logic [15:0] v, bit calm);
      patch_item_type it;
      it = '{ACT_EVAL, 2'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), u, v, 1'b0, calm};
      return it;
   endfunction

   // Driver: change inputs at the falling edge, hold an unaccepted item.
   always @(negedge clock) begin
      patch_item_type it;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].drain && expected_samples.size() > 0)) begin
         it = pending_items.pop_front();
         start <= 1'b1;
         req_action <= it.action;
         req_row <= it.row;
         req_col <= it.col;
         req_px <= it.px;
         req_py <= it.py;
         req_pz <= it.pz;
         req_u <= it.u;
         req_v <= it.v;
         if (!it.calm && $urandom_range(0, 11) == 0) gap_left <= $urandom_range(1, 17);
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predict on each accepted request, check each result strobe.
   always @(posedge clock) begin
      surface_sample_type want;
      taken <= start && !busy && !reset;
      if (!reset) begin
         if (start && !busy) begin
            if (req_action == ACT_LOAD) begin
               grid_pts[{req_row, req_col}][0] = longint'(req_px);
               grid_pts[{req_row, req_col}][1] = longint'(req_py);
               grid_pts[{req_row, req_col}][2] = longint'(req_pz);
            end else begin
               expected_samples.push_back(sample_patch(req_u, req_v));
            end
         end
         if (rsp_strobe) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected result, point %0d %0d %0d", $time,
                        rsp_point_x, rsp_point_y, rsp_point_z);
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_point_x !== want.px) begin
                  $display("%0t: point_x expected %0d actual %0d", $time, want.px, rsp_point_x);
                  mismatches++;
               end
               if (rsp_point_y !== want.py) begin
                  $display("%0t: point_y expected %0d actual %0d", $time, want.py, rsp_point_y);
                  mismatches++;
               end
               if (rsp_point_z !== want.pz) begin
                  $display("%0t: point_z expected %0d actual %0d", $time, want.pz, rsp_point_z);
                  mismatches++;
               end
               if (rsp_normal_x !== want.nx) begin
                  $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, rsp_normal_x);
                  mismatches++;
               end
               if (rsp_normal_y !== want.ny) begin
                  $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, rsp_normal_y);
                  mismatches++;
               end
               if (rsp_normal_z !== want.nz) begin
                  $display("%0t: normal_z expected %0d actual %0d", $time, want.nz, rsp_normal_z);
                  mismatches++;
               end
            end
         end
         // Watchdog: count cycles where neither side moves a transaction.
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("** bicubic_bezier_patch_eval_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      patch_item_type it;
      bit calm;
      for (int i = 0; i < 16; i++)
         for (int c = 0; c < 3; c++) grid_pts[i][c] = 0;

      // Directed: fill the grid with extreme x and y, then evaluate at corners,
      // the midpoint, one LSB and parameters above one (saturate).
      for (int i = 0; i < 16; i++)
         pending_items.push_back(load_item(i / 4, i % 4,
            (i % 2) ? 16'h7fff : 16'h8000, (i % 3) ? 16'h8000 : 16'h7fff,
            16'(i * 997 - 8000), 1'b0));
      pending_items.push_back(eval_item(16'd0, 16'd0, 1'b0));
      pending_items.push_back(eval_item(16'd32768, 16'd0, 1'b0));
      pending_items.push_back(eval_item(16'd0, 16'd32768, 1'b0));
      pending_items.push_back(eval_item(16'd32768, 16'd32768, 1'b0));
      pending_items.push_back(eval_item(16'd16384, 16'd16384, 1'b0));
      pending_items.push_back(eval_item(16'd1, 16'd32767, 1'b0));
      pending_items.push_back(eval_item(16'hffff, 16'd32769, 1'b0));
      pending_items.push_back(eval_item(16'd32769, 16'hffff, 1'b0));
      pending_items.push_back(eval_item(16'h7fff, 16'h8001, 1'b0));

      // Random: every entry is already written, so any mix is legal.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= RANDOM_ITEMS - CALM_TAIL);
         if ($urandom_range(0, 9) < 3)
            it = load_item($urandom_range(0, 3), $urandom_range(0, 3),
                           pick_coord(), pick_coord(), pick_coord(), calm);
         else
            it = eval_item(pick_param(), pick_param(), calm);
         if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) it.drain = 1'b1;
         pending_items.push_back(it);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain stimulus, then results, then let the pipeline settle.
      while (pending_items.size() > 0 || start) @(posedge clock);
      while (expected_samples.size() > 0) @(posedge clock);
      repeat (EVAL_LATENCY + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("** bicubic_bezier_patch_eval_unit: PASSED **");
      end else begin
         $display("** bicubic_bezier_patch_eval_unit: FAILED **");
      end
      $finish;
   end

endmodule
